FILE: hw/rtl/sha_pkg.sv
// shared types, constants and tables of the sha-256 stream hasher
`default_nettype none
package sha_pkg;

    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] FILL_LEN   = 6'd56;
    localparam logic [2:0] OIDX_LAST  = 3'd7;
    localparam logic [7:0] PAD_MARK   = 8'h80;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_ROUND,
        S_FOLD,
        S_PAD,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        BSEL_IN,
        BSEL_MARK,
        BSEL_ZERO,
        BSEL_LEN
    } t_bsel;

    typedef struct packed {
        logic       push;
        t_bsel      bsel;
        logic       add_len;
        logic       pre;
        logic       round;
        logic [5:0] kidx;
        logic       fold;
        logic       load_out;
        logic [2:0] oidx;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic [5:0] fill;
        logic       out_free;
    } t_stat;

endpackage
`default_nettype wire

FILE: hw/rtl/sha_in_if.sv
// input channel: one optional message byte and an end flag per word
`default_nettype none
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, has_byte, data_byte, is_last, input ready);
    modport sink (input valid, has_byte, data_byte, is_last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sha_out_if.sv
// output channel: one digest word with its position per word
`default_nettype none
interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sha_dp.sv
// sha-256 datapath: byte packing, schedule window, round unit, chain and output register
`default_nettype none
module sha_dp (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire sha_pkg::t_cmd i_cmd,
    input  wire logic [7:0]   i_byte,
    input  wire logic         i_out_ready,
    output sha_pkg::t_stat    o_st,
    output logic              o_valid,
    output logic [31:0]       o_word,
    output logic [2:0]        o_idx,
    output logic              o_last
);

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [5:0]  r_fill;
    logic [63:0] r_len;
    logic [23:0] r_asm;
    logic [31:0] r_w [16];
    logic [31:0] r_kw;
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic        r_ovalid;
    logic [31:0] r_oword;
    logic [2:0]  r_oidx;
    logic        r_olast;

    logic [7:0]  n_byte;
    logic [31:0] n_wnew;
    logic [31:0] n_t1;
    logic [31:0] n_t2;

    always_comb begin
        unique case (i_cmd.bsel)
            sha_pkg::BSEL_IN:   n_byte = i_byte;
            sha_pkg::BSEL_MARK: n_byte = sha_pkg::PAD_MARK;
            sha_pkg::BSEL_ZERO: n_byte = '0;
            sha_pkg::BSEL_LEN:  n_byte = r_len[{~r_fill[2:0], 3'b000} +: 8];
            default:            n_byte = '0;
        endcase
    end

    // next schedule word from the sixteen-word window
    assign n_wnew = r_w[0]
                  + (ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3))
                  + r_w[9]
                  + (ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10));

    // k plus w comes in pre-added from the previous cycle
    assign n_t1 = r_v[7]
                + (ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25))
                + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                + r_kw;
    assign n_t2 = (ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22))
                + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_len    <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha_pkg::IV[i];
            end
        end else begin
            if (i_cmd.push) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.add_len) begin
                r_len <= r_len + 64'd8;
            end
            if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            if (i_cmd.finish) begin
                r_len <= '0;
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= sha_pkg::IV[i];
                end
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_asm <= {r_asm[15:0], n_byte};
            if (r_fill[1:0] == 2'b11) begin
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i + 1];
                end
                r_w[15] <= {r_asm, n_byte};
            end
        end
        if (i_cmd.pre) begin
            r_kw <= sha_pkg::K_TAB[i_cmd.kidx] + r_w[0];
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end
        if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= n_wnew;
            r_kw    <= sha_pkg::K_TAB[i_cmd.kidx] + r_w[1];
            r_v[0]  <= n_t1 + n_t2;
            r_v[1]  <= r_v[0];
            r_v[2]  <= r_v[1];
            r_v[3]  <= r_v[2];
            r_v[4]  <= r_v[3] + n_t1;
            r_v[5]  <= r_v[4];
            r_v[6]  <= r_v[5];
            r_v[7]  <= r_v[6];
        end
        if (i_cmd.load_out) begin
            r_oword <= r_h[i_cmd.oidx];
            r_oidx  <= i_cmd.oidx;
            r_olast <= (i_cmd.oidx == sha_pkg::OIDX_LAST);
        end
    end

    assign o_st.fill     = r_fill;
    assign o_st.out_free = !r_ovalid || i_out_ready;
    assign o_valid       = r_ovalid;
    assign o_word        = r_oword;
    assign o_idx         = r_oidx;
    assign o_last        = r_olast;

    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_len |=> (r_len == $past(r_len) + 64'd8))
        else $error("length counter did not step by one byte");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_ovalid)
        else $error("digest word loaded but not presented");

    a_finish_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_h[0] == sha_pkg::IV[0] && r_len == '0))
        else $error("chain not restored after digest");

    a_push_vs_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.push && (i_cmd.round || i_cmd.pre)))
        else $error("byte pushed while the schedule window is in use");

endmodule
`default_nettype wire

FILE: hw/rtl/sha_ctrl.sv
// sha-256 controller: input acceptance, padding sequence, rounds and digest readout
`default_nettype none
module sha_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_has_byte,
    input  wire logic          i_is_last,
    input  wire sha_pkg::t_stat i_st,
    output logic               o_in_ready,
    output sha_pkg::t_cmd      o_cmd
);

    sha_pkg::t_state r_state, n_state;
    logic [5:0]      r_rnd, n_rnd;
    logic [2:0]      r_oidx, n_oidx;
    logic            r_padding, n_padding;
    logic            r_first, n_first;
    logic            r_lenph, n_lenph;
    logic            r_done, n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sha_pkg::S_IDLE;
            r_rnd     <= '0;
            r_oidx    <= '0;
            r_padding <= 1'b0;
            r_first   <= 1'b0;
            r_lenph   <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rnd     <= n_rnd;
            r_oidx    <= n_oidx;
            r_padding <= n_padding;
            r_first   <= n_first;
            r_lenph   <= n_lenph;
            r_done    <= n_done;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_rnd      = r_rnd;
        n_oidx     = r_oidx;
        n_padding  = r_padding;
        n_first    = r_first;
        n_lenph    = r_lenph;
        n_done     = r_done;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.bsel = sha_pkg::BSEL_IN;

        unique case (r_state)
            sha_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.push    = i_has_byte;
                    o_cmd.add_len = i_has_byte;
                    n_first       = 1'b1;
                    n_lenph       = 1'b0;
                    n_done        = 1'b0;
                    if (i_has_byte && i_st.fill == sha_pkg::FILL_LAST) begin
                        // full block first, padding after if the message ends here
                        n_state   = sha_pkg::S_PRE;
                        n_padding = i_is_last;
                    end else if (i_is_last) begin
                        n_state   = sha_pkg::S_PAD;
                        n_padding = 1'b1;
                    end
                end
            end
            sha_pkg::S_PRE: begin
                o_cmd.pre  = 1'b1;
                o_cmd.kidx = '0;
                n_rnd      = '0;
                n_state    = sha_pkg::S_ROUND;
            end
            sha_pkg::S_ROUND: begin
                o_cmd.round = 1'b1;
                o_cmd.kidx  = r_rnd + 6'd1;
                n_rnd       = r_rnd + 6'd1;
                if (r_rnd == sha_pkg::ROUND_LAST) begin
                    n_state = sha_pkg::S_FOLD;
                end
            end
            sha_pkg::S_FOLD: begin
                o_cmd.fold = 1'b1;
                if (r_done) begin
                    n_state = sha_pkg::S_OUT;
                    n_oidx  = '0;
                end else if (r_padding) begin
                    n_state = sha_pkg::S_PAD;
                end else begin
                    n_state = sha_pkg::S_IDLE;
                end
            end
            sha_pkg::S_PAD: begin
                o_cmd.push = 1'b1;
                if (r_first) begin
                    o_cmd.bsel = sha_pkg::BSEL_MARK;
                    n_first    = 1'b0;
                end else if (r_lenph || i_st.fill == sha_pkg::FILL_LEN) begin
                    // length bytes fill positions 56 to 63
                    o_cmd.bsel = sha_pkg::BSEL_LEN;
                    n_lenph    = 1'b1;
                end else begin
                    o_cmd.bsel = sha_pkg::BSEL_ZERO;
                end
                if (i_st.fill == sha_pkg::FILL_LAST) begin
                    n_state = sha_pkg::S_PRE;
                    n_done  = !r_first && r_lenph;
                end
            end
            sha_pkg::S_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.oidx     = r_oidx;
                    n_oidx         = r_oidx + 3'd1;
                    if (r_oidx == sha_pkg::OIDX_LAST) begin
                        o_cmd.finish = 1'b1;
                        n_padding    = 1'b0;
                        n_done       = 1'b0;
                        n_state      = sha_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = sha_pkg::S_IDLE;
            end
        endcase
    end

    a_pre_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha_pkg::S_PRE) |=> (r_state == sha_pkg::S_ROUND && r_rnd == '0))
        else $error("rounds did not start at round zero");

    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha_pkg::S_ROUND && r_rnd == sha_pkg::ROUND_LAST)
        |=> (r_state == sha_pkg::S_FOLD))
        else $error("missing chain fold after last round");

    a_pre_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha_pkg::S_PRE) |-> (i_st.fill == '0))
        else $error("compression started on a partial block");

    a_out_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha_pkg::S_OUT && o_cmd.load_out && r_oidx == sha_pkg::OIDX_LAST)
        |=> (r_state == sha_pkg::S_IDLE))
        else $error("no return to idle after final digest word");

endmodule
`default_nettype wire

FILE: hw/rtl/sha256_stream_hasher.sv
// sha-256 stream hasher top level
//
//  channel  dir  word                                   handshake
//  i_in     in   has_byte, data_byte[7:0], is_last      valid / ready
//  o_out    out  digest_word[31:0], word_index, last_word valid / ready
//
// one word is taken per cycle while idle; a byte that completes a block
// starts compression: a load step, 64 rounds (one per cycle) and a fold step
// the end flag adds padding at one byte per cycle, one or two compressions,
// then eight digest words at up to one per cycle through the output register
// synchronous active-low reset restores the initial hash values, no clear pass
// output stalls hold the readout; input is not taken while a block is in work
`default_nettype none
module sha256_stream_hasher (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sha_in_if.sink    i_in,
    sha_out_if.source o_out
);

    sha_pkg::t_cmd  w_cmd;
    sha_pkg::t_stat w_st;

    sha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_has_byte (i_in.has_byte),
        .i_is_last  (i_in.is_last),
        .i_st       (w_st),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd)
    );

    sha_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_byte      (i_in.data_byte),
        .i_out_ready (o_out.ready),
        .o_st        (w_st),
        .o_valid     (o_out.valid),
        .o_word      (o_out.digest_word),
        .o_idx       (o_out.word_index),
        .o_last      (o_out.last_word)
    );

endmodule
`default_nettype wire
